[design/assert_macros.svh]
// Assertion macros shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define WSFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define WSFD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[design/wsfd_pkg.sv]
// Shared types and constants for the WebSocket frame deframer.
`default_nettype none

package wsfd_pkg;

    // Event kinds reported on the result channel.
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_CLOSE   = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Frame opcodes.
    localparam logic [3:0] OPC_CONT  = 4'h0;
    localparam logic [3:0] OPC_TEXT  = 4'h1;
    localparam logic [3:0] OPC_BIN   = 4'h2;
    localparam logic [3:0] OPC_CLOSE = 4'h8;
    localparam logic [3:0] OPC_PING  = 4'h9;
    localparam logic [3:0] OPC_PONG  = 4'hA;

    // Length encoding and header sizes.
    localparam logic [6:0] LEN_MAGIC16 = 7'd126;
    localparam logic [6:0] LEN_MAGIC64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] MASK_BYTES  = 4'd4;

    // Status reported for an unknown opcode.
    localparam logic [15:0] ERR_CODE = 16'd1000;

    // One result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic        is_text;
        logic        last_of_message;
        logic [15:0] close_code;
    } event_t;

endpackage

`default_nettype wire

[design/wsfd_parser.sv]
// Frame header parser, payload unmasking and event generation.
`default_nettype none
`include "assert_macros.svh"

module wsfd_parser (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 step,        // consume rx_byte this cycle
    input  wire  [7:0]          rx_byte,
    output logic                has_result,  // rx_byte produces an event
    output wsfd_pkg::event_t    ev
);

    typedef enum logic [4:0] {
        PH_OPCODE  = 5'b00001,
        PH_LEN     = 5'b00010,
        PH_EXT     = 5'b00100,
        PH_MASK    = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        stopped_reg, stopped_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic [63:0] remain_reg, remain_next;   // length, then bytes still to come
    logic [3:0]  count_reg, count_next;     // extended length or mask bytes left
    logic [31:0] mask_reg, mask_next;       // current key byte in the top byte
    logic        first_reg, first_next;     // at payload byte 0
    logic        second_reg, second_next;   // at payload byte 1
    logic [7:0]  close_hi_reg, close_hi_next;

    logic [3:0]  opc;
    logic [6:0]  len7;
    logic [7:0]  plain;
    logic        last;
    logic        is_msg;
    logic        is_text;
    logic        known_opc;

    assign opc     = rx_byte[3:0];
    assign len7    = rx_byte[6:0];
    assign plain   = rx_byte ^ mask_reg[31:24];
    assign last    = (remain_reg == 64'd1);
    assign is_msg  = (opcode_reg == wsfd_pkg::OPC_TEXT) || (opcode_reg == wsfd_pkg::OPC_BIN);
    assign is_text = (opcode_reg == wsfd_pkg::OPC_TEXT);
    assign known_opc = (opc == wsfd_pkg::OPC_CONT) || (opc == wsfd_pkg::OPC_TEXT) ||
                       (opc == wsfd_pkg::OPC_BIN)  || (opc == wsfd_pkg::OPC_CLOSE) ||
                       (opc == wsfd_pkg::OPC_PING) || (opc == wsfd_pkg::OPC_PONG);

    // Next state and event for the byte in hand.
    always_comb begin
        phase_next    = phase_reg;
        stopped_next  = stopped_reg;
        opcode_next   = opcode_reg;
        remain_next   = remain_reg;
        count_next    = count_reg;
        mask_next     = mask_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        close_hi_next = close_hi_reg;
        has_result    = 1'b0;
        ev            = '0;
        if (!stopped_reg) begin
            case (phase_reg)
                PH_LEN: begin
                    if (len7 == wsfd_pkg::LEN_MAGIC16) begin
                        remain_next = '0;
                        count_next  = wsfd_pkg::EXT16_BYTES;
                        phase_next  = PH_EXT;
                    end else if (len7 == wsfd_pkg::LEN_MAGIC64) begin
                        remain_next = '0;
                        count_next  = wsfd_pkg::EXT64_BYTES;
                        phase_next  = PH_EXT;
                    end else begin
                        remain_next = {57'd0, len7};
                        count_next  = wsfd_pkg::MASK_BYTES;
                        phase_next  = PH_MASK;
                    end
                end
                PH_EXT: begin
                    // Big-endian extended length, one byte at a time.
                    remain_next = {remain_reg[55:0], rx_byte};
                    count_next  = count_reg - 4'd1;
                    if (count_reg == 4'd1) begin
                        count_next = wsfd_pkg::MASK_BYTES;
                        phase_next = PH_MASK;
                    end
                end
                PH_MASK: begin
                    mask_next  = {mask_reg[23:0], rx_byte};
                    count_next = count_reg - 4'd1;
                    if (count_reg == 4'd1) begin
                        first_next  = 1'b1;
                        second_next = 1'b0;
                        if (remain_reg != 64'd0) begin
                            phase_next = PH_PAYLOAD;
                        end else begin
                            // Empty frame: a message or close frame is reported right after the key.
                            phase_next = PH_OPCODE;
                            if (is_msg) begin
                                has_result         = 1'b1;
                                ev.kind            = wsfd_pkg::KIND_EMPTY;
                                ev.is_text         = is_text;
                                ev.last_of_message = 1'b1;
                            end else if (opcode_reg == wsfd_pkg::OPC_CLOSE) begin
                                has_result   = 1'b1;
                                stopped_next = 1'b1;
                                ev.kind      = wsfd_pkg::KIND_CLOSE;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    // Rotate the key so the next byte's key byte is on top.
                    mask_next   = {mask_reg[23:0], mask_reg[31:24]};
                    remain_next = remain_reg - 64'd1;
                    first_next  = 1'b0;
                    second_next = first_reg;
                    if (last) begin
                        phase_next = PH_OPCODE;
                    end
                    if (is_msg) begin
                        has_result         = 1'b1;
                        ev.kind            = wsfd_pkg::KIND_PAYLOAD;
                        ev.data_byte       = plain;
                        ev.is_text         = is_text;
                        ev.last_of_message = last;
                    end else if (opcode_reg == wsfd_pkg::OPC_CLOSE) begin
                        if (first_reg) begin
                            close_hi_next = plain;
                            if (last) begin
                                has_result   = 1'b1;
                                stopped_next = 1'b1;
                                ev.kind      = wsfd_pkg::KIND_CLOSE;
                            end
                        end else if (second_reg) begin
                            has_result    = 1'b1;
                            stopped_next  = 1'b1;
                            ev.kind       = wsfd_pkg::KIND_CLOSE;
                            ev.close_code = {close_hi_reg, plain};
                        end
                    end
                end
                default: begin
                    // Opcode byte; FIN and reserved bits are ignored.
                    opcode_next = opc;
                    if (known_opc) begin
                        phase_next = PH_LEN;
                    end else begin
                        phase_next    = PH_OPCODE;
                        has_result    = 1'b1;
                        stopped_next  = 1'b1;
                        ev.kind       = wsfd_pkg::KIND_ERROR;
                        ev.close_code = wsfd_pkg::ERR_CODE;
                    end
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_OPCODE;
            stopped_reg <= 1'b0;
        end else if (step) begin
            phase_reg   <= phase_next;
            stopped_reg <= stopped_next;
        end
    end

    // Frame context; each field is written before it is used.
    always_ff @(posedge aclk) begin
        if (step) begin
            opcode_reg   <= opcode_next;
            remain_reg   <= remain_next;
            count_reg    <= count_next;
            mask_reg     <= mask_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
            close_hi_reg <= close_hi_next;
        end
    end

    `WSFD_ASSERT(a_stop_sticks, stopped_reg |=> stopped_reg, "stop flag cleared without reset")
    `WSFD_ASSERT(a_last_ends_frame, step && has_result && ev.kind == wsfd_pkg::KIND_PAYLOAD && ev.last_of_message |=> phase_reg == PH_OPCODE, "last payload byte did not end the frame")

endmodule

`default_nettype wire

[design/websocket_frame_deframer_top.sv]
// Input register, parser, then result register, which drives m_*. Throughput:
// one byte per cycle, set by the single parse stage between the two registers;
// bytes with no result pass freely, others wait for a free result register.
// Reset (aresetn low at an edge) empties both registers and returns the parser
// to waiting for an opcode byte with the stop flag cleared.
`default_nettype none
`include "assert_macros.svh"

module websocket_frame_deframer_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,    // [7:0] data_byte, [23:8] close_code
    output logic [2:0]  m_tuser,    // [1:0] event_kind, [2] is_text
    output logic        m_tlast     // last_of_message
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg, out_valid_next;
    wsfd_pkg::event_t out_reg;

    logic             has_result;
    wsfd_pkg::event_t ev;
    logic             out_free;
    logic             fire;

    // The held byte is parsed when its result, if any, has room.
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && (!has_result || out_free);
    assign s_tready = !in_valid_reg || fire;

    wsfd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (fire),
        .rx_byte    (in_byte_reg),
        .has_result (has_result),
        .ev         (ev)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Result register.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire && has_result) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && has_result) begin
            out_reg <= ev;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.close_code, out_reg.data_byte};
    assign m_tuser  = {out_reg.is_text, out_reg.kind};
    assign m_tlast  = out_reg.last_of_message;

    `WSFD_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_tvalid && s_tready,
        "reset left a request pending")
    `WSFD_ASSERT(a_nothing_after_stop, m_tvalid && m_tready && m_tuser[1] |=> !m_tvalid,
        "result after close or error")
    `WSFD_ASSERT(a_error_code,
        m_tvalid && m_tuser[1:0] == wsfd_pkg::KIND_ERROR |->
        m_tdata[23:8] == wsfd_pkg::ERR_CODE && m_tdata[7:0] == 8'd0,
        "bad error result")

endmodule

`default_nettype wire
